@@ src/crsf_frame_parser_channel_scaler_top_assert.svh @@
`ifndef CRSF_FRAME_PARSER_CHANNEL_SCALER_TOP_ASSERT_SVH
`define CRSF_FRAME_PARSER_CHANNEL_SCALER_TOP_ASSERT_SVH

// concurrent check on a clock, skipped while reset is low
`define CFSC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same check, also evaluated during reset
`define CFSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/cfsc_pkg.sv @@
package cfsc_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int NUM_CHANNELS = 16;
    localparam int CHANNEL_BITS = 11;

    localparam int AW         = $clog2(BUFFER_DEPTH);
    localparam int FILL_W     = AW + 1;
    localparam int CMP_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 4;
    localparam int VAL_W      = 16;
    localparam int RAW_W      = 11;
    localparam int MAXPL_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int CH_PAYLOAD_BYTES = (NUM_CHANNELS * CHANNEL_BITS + 7) / 8;
    localparam int CH_FRAME_LEN     = CH_PAYLOAD_BYTES + 2;
    localparam int MIN_LEN          = 3;
    localparam int LEN_OVERHEAD     = 2;
    localparam int TYPE_OFS         = 2;
    localparam int PAYLOAD_OFS      = 3;

    localparam int SCALE_HIGH  = 2000;
    localparam int SCALE_BASE  = 1000;
    localparam int SCALE_STEPS = SCALE_HIGH - SCALE_BASE;

    localparam int MAG_W  = (CHANNEL_BITS > RAW_W) ? CHANNEL_BITS : RAW_W;
    localparam int NUM_W  = $clog2(SCALE_STEPS * ((1 << MAG_W) - 1) + 1);
    localparam int DCNT_W = $clog2(NUM_W);

    localparam int ACC_W    = CHANNEL_BITS + BYTE_W;
    localparam int BITS_W   = $clog2(ACC_W + 1);
    localparam int CH_CNT_W = $clog2(NUM_CHANNELS + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]       RST_CRC_POLY = 8'd213;
    localparam logic [7:0]       RST_ADDR     = 8'd200;
    localparam logic [7:0]       RST_TYPE     = 8'd22;
    localparam logic [MAXPL_W-1:0] RST_MAXPL  = 6'd60;
    localparam logic [RAW_W-1:0] RST_RAW_AT   = 11'd191;
    localparam logic [RAW_W-1:0] RST_SPAN     = 11'd1639;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CRC_POLY    = 3'd0,
        REG_ACC_ADDR    = 3'd1,
        REG_CH_TYPE     = 3'd2,
        REG_MAX_PL      = 3'd3,
        REG_RAW_AT_1000 = 3'd4,
        REG_RAW_SPAN    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]         poly;
        logic [7:0]         addr;
        logic [7:0]         ftype;
        logic [MAXPL_W-1:0] max_pl;
    } t_front_cfg;

    typedef struct packed {
        logic [RAW_W-1:0] raw_at;
        logic [RAW_W-1:0] span;
    } t_back_cfg;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] raw;
        logic [IDX_W-1:0]        idx;
        logic                    last;
        logic                    first;
    } t_chan_item;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ src/cfsc_in_if.sv @@
interface cfsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ src/cfsc_out_if.sv @@
interface cfsc_out_if;
    logic                          valid;
    logic                          ready;
    logic [cfsc_pkg::IDX_W-1:0]    channel_index;
    logic [cfsc_pkg::VAL_W-1:0]    channel_value;
    logic                          last_channel;
    logic                          link_came_up;

    modport source (output valid, output channel_index, output channel_value,
                    output last_channel, output link_came_up, input ready);
    modport sink (input valid, input channel_index, input channel_value,
                  input last_channel, input link_came_up, output ready);
endinterface

@@ src/cfsc_ram.sv @@
module cfsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/cfsc_queue.sv @@
module cfsc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cfsc_pkg::t_chan_item i_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output cfsc_pkg::t_chan_item o_item,
    output logic                 o_empty
);
    cfsc_pkg::t_chan_item r_slot [cfsc_pkg::QUEUE_DEPTH];
    logic [cfsc_pkg::Q_AW-1:0] r_wr;
    logic [cfsc_pkg::Q_AW-1:0] r_rd;
    logic [cfsc_pkg::Q_AW:0]   r_cnt;
    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (cfsc_pkg::Q_AW+1)'(cfsc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

@@ src/cfsc_front.sv @@
module cfsc_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cfsc_pkg::t_front_cfg   i_cfg,
    cfsc_in_if.sink                i_rx,
    output logic                   o_push,
    output cfsc_pkg::t_chan_item   o_item,
    input  logic                   i_full
);
    typedef enum logic [2:0] {
        F_IDLE, F_SCAN, F_LEN, F_CRC, F_CHK, F_ADR, F_TYP, F_DEC
    } t_fstate;

    localparam int AW = cfsc_pkg::AW;
    localparam int FW = cfsc_pkg::FILL_W;
    localparam int CW = cfsc_pkg::CMP_W;

    t_fstate r_state, n_state;
    logic [AW-1:0]  r_head, n_head;
    logic [FW-1:0]  r_fill, n_fill;
    logic [AW-1:0]  r_ofs, n_ofs;
    logic [7:0]     r_len, n_len;
    logic [7:0]     r_crc, n_crc;
    logic           r_addr_ok, n_addr_ok;
    logic           r_first, n_first;
    logic           r_link, n_link;
    logic [cfsc_pkg::ACC_W-1:0]    r_acc, n_acc;
    logic [cfsc_pkg::BITS_W-1:0]   r_bits, n_bits;
    logic [cfsc_pkg::CH_CNT_W-1:0] r_ch, n_ch;

    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic [CW-1:0] frame_bytes;

    cfsc_ram #(.WIDTH(cfsc_pkg::BYTE_W), .DEPTH(cfsc_pkg::BUFFER_DEPTH)) u_buf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_rx.rx_byte),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // read address follows next state, so rdata always holds buf[head + ofs]
    assign raddr       = n_head + n_ofs;
    assign waddr       = r_head + r_fill[AW-1:0];
    assign i_rx.ready  = (r_state == F_IDLE);
    assign frame_bytes = CW'(r_len) + CW'(cfsc_pkg::LEN_OVERHEAD);

    assign o_item.raw   = r_acc[cfsc_pkg::CHANNEL_BITS-1:0];
    assign o_item.idx   = cfsc_pkg::IDX_W'(r_ch);
    assign o_item.last  = (r_ch == cfsc_pkg::CH_CNT_W'(cfsc_pkg::NUM_CHANNELS - 1));
    assign o_item.first = r_first;

    always_comb begin
        logic [CW-1:0] len_ext;
        n_state   = r_state;
        n_head    = r_head;
        n_fill    = r_fill;
        n_ofs     = r_ofs;
        n_len     = r_len;
        n_crc     = r_crc;
        n_addr_ok = r_addr_ok;
        n_first   = r_first;
        n_link    = r_link;
        n_acc     = r_acc;
        n_bits    = r_bits;
        n_ch      = r_ch;
        we        = 1'b0;
        o_push    = 1'b0;
        len_ext   = CW'(rdata);
        unique case (r_state)
            F_IDLE: begin
                if (i_rx.valid) begin
                    we = 1'b1;
                    // full buffer: oldest byte is overwritten in place
                    if (r_fill == FW'(cfsc_pkg::BUFFER_DEPTH)) begin
                        n_head = r_head + 1'b1;
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_ofs   = AW'(1);
                    n_state = F_SCAN;
                end
            end
            F_SCAN: begin
                n_ofs   = AW'(1);
                n_state = (r_fill > FW'(1)) ? F_LEN : F_IDLE;
            end
            F_LEN: begin
                if (len_ext < CW'(cfsc_pkg::MIN_LEN) ||
                    len_ext > CW'(i_cfg.max_pl) + CW'(cfsc_pkg::LEN_OVERHEAD)) begin
                    n_head  = r_head + 1'b1;
                    n_fill  = r_fill - 1'b1;
                    n_ofs   = AW'(1);
                    n_state = F_SCAN;
                end else if (CW'(r_fill) >= len_ext + CW'(cfsc_pkg::LEN_OVERHEAD)) begin
                    n_len   = rdata;
                    n_crc   = '0;
                    n_ofs   = AW'(cfsc_pkg::TYPE_OFS);
                    n_state = F_CRC;
                end else begin
                    n_state = F_IDLE;
                end
            end
            F_CRC: begin
                n_crc = cfsc_pkg::crc8_byte(r_crc, rdata, i_cfg.poly);
                n_ofs = r_ofs + 1'b1;
                if (CW'(r_ofs) == CW'(r_len)) begin
                    n_state = F_CHK;
                end
            end
            F_CHK: begin
                if (rdata != r_crc) begin
                    n_head  = r_head + 1'b1;
                    n_fill  = r_fill - 1'b1;
                    n_ofs   = AW'(1);
                    n_state = F_SCAN;
                end else begin
                    n_ofs   = '0;
                    n_state = F_ADR;
                end
            end
            F_ADR: begin
                n_addr_ok = (rdata == i_cfg.addr);
                n_ofs     = AW'(cfsc_pkg::TYPE_OFS);
                n_state   = F_TYP;
            end
            F_TYP: begin
                if (r_addr_ok && rdata == i_cfg.ftype &&
                    r_len == 8'(cfsc_pkg::CH_FRAME_LEN)) begin
                    n_first = !r_link;
                    n_link  = 1'b1;
                    n_acc   = '0;
                    n_bits  = '0;
                    n_ch    = '0;
                    n_ofs   = AW'(cfsc_pkg::PAYLOAD_OFS);
                    n_state = F_DEC;
                end else begin
                    n_head  = r_head + AW'(frame_bytes);
                    n_fill  = r_fill - FW'(frame_bytes);
                    n_ofs   = AW'(1);
                    n_state = F_SCAN;
                end
            end
            F_DEC: begin
                if (r_ch == cfsc_pkg::CH_CNT_W'(cfsc_pkg::NUM_CHANNELS)) begin
                    n_head  = r_head + AW'(frame_bytes);
                    n_fill  = r_fill - FW'(frame_bytes);
                    n_ofs   = AW'(1);
                    n_state = F_SCAN;
                end else if (r_bits >= cfsc_pkg::BITS_W'(cfsc_pkg::CHANNEL_BITS)) begin
                    if (!i_full) begin
                        o_push = 1'b1;
                        n_acc  = r_acc >> cfsc_pkg::CHANNEL_BITS;
                        n_bits = r_bits - cfsc_pkg::BITS_W'(cfsc_pkg::CHANNEL_BITS);
                        n_ch   = r_ch + 1'b1;
                    end
                end else begin
                    // payload is LSB first: new byte lands above bits held
                    n_acc  = r_acc | (cfsc_pkg::ACC_W'(rdata) << r_bits);
                    n_bits = r_bits + cfsc_pkg::BITS_W'(cfsc_pkg::BYTE_W);
                    n_ofs  = r_ofs + 1'b1;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ofs     <= n_ofs;
        r_len     <= n_len;
        r_crc     <= n_crc;
        r_addr_ok <= n_addr_ok;
        r_first   <= n_first;
        r_acc     <= n_acc;
        r_bits    <= n_bits;
        r_ch      <= n_ch;
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_link  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_link  <= n_link;
        end
    end
endmodule

@@ src/cfsc_back.sv @@
module cfsc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cfsc_pkg::t_back_cfg  i_cfg,
    input  cfsc_pkg::t_chan_item i_item,
    input  logic                 i_empty,
    output logic                 o_pop,
    cfsc_out_if.source           o_ch
);
    typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_OUT} t_bstate;

    localparam int MW = cfsc_pkg::MAG_W;
    localparam int NW = cfsc_pkg::NUM_W;

    t_bstate r_state;
    cfsc_pkg::t_chan_item r_item;
    logic                 r_neg;
    logic [MW-1:0]        r_mag;
    logic [NW-1:0]        r_num;
    logic [MW-1:0]        r_rem;
    logic [cfsc_pkg::DCNT_W-1:0] r_cnt;

    logic                        r_ovalid;
    logic [cfsc_pkg::IDX_W-1:0]  r_oidx;
    logic [cfsc_pkg::VAL_W-1:0]  r_oval;
    logic                        r_olast;
    logic                        r_ofirst;

    logic [MW-1:0] raw_ext;
    logic [MW-1:0] at_ext;
    logic [MW-1:0] span_eff;
    logic [MW:0]   trial;
    logic          fits;
    logic [cfsc_pkg::VAL_W-1:0] q16;
    logic [cfsc_pkg::VAL_W-1:0] value;
    logic          out_free;

    assign raw_ext  = MW'(i_item.raw);
    assign at_ext   = MW'(i_cfg.raw_at);
    assign span_eff = (i_cfg.span == '0) ? MW'(1) : MW'(i_cfg.span);
    assign trial    = {r_rem, r_num[NW-1]};
    assign fits     = (trial >= {1'b0, span_eff});
    assign q16      = cfsc_pkg::VAL_W'(r_num);
    assign value    = (r_neg ? (~q16 + 1'b1) : q16) + cfsc_pkg::VAL_W'(cfsc_pkg::SCALE_BASE);
    assign out_free = !r_ovalid || o_ch.ready;
    assign o_pop    = (r_state == B_IDLE) && !i_empty;

    assign o_ch.valid         = r_ovalid;
    assign o_ch.channel_index = r_oidx;
    assign o_ch.channel_value = r_oval;
    assign o_ch.last_channel  = r_olast;
    assign o_ch.link_came_up  = r_ofirst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == B_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_item  <= i_item;
                        // divide magnitudes, negate after: truncation toward zero
                        r_neg   <= raw_ext < at_ext;
                        r_mag   <= (raw_ext < at_ext) ? (at_ext - raw_ext) : (raw_ext - at_ext);
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_num   <= NW'(r_mag * cfsc_pkg::SCALE_STEPS);
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_rem <= fits ? MW'(trial - {1'b0, span_eff}) : MW'(trial);
                    r_num <= {r_num[NW-2:0], fits};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == cfsc_pkg::DCNT_W'(NW - 1)) begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        r_oidx   <= r_item.idx;
                        r_oval   <= value;
                        r_olast  <= r_item.last;
                        r_ofirst <= r_item.first;
                        r_state  <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end
endmodule

@@ src/crsf_frame_parser_channel_scaler_top.sv @@
// Channel  Dir  Handshake     Payload
// i_rx     in   valid/ready   rx_byte[7:0]
// o_ch     out  valid/ready   channel_index[3:0], channel_value[15:0],
//                             last_channel, link_came_up
// cfg      in   i_cfg_we      i_cfg_idx[2:0], i_cfg_wdata[10:0]
// A byte is stored in F_IDLE and tested in F_SCAN, then F_LEN if two or more are held;
// a complete frame then runs F_CRC and F_CHK, and F_ADR and F_TYP when its CRC passes;
// each dropped byte costs one more rescan from the new head (buffer read port).
// A channel frame then unpacks its channels in F_DEC; each channel in turn passes B_MUL,
// the serial divider in B_DIV and B_OUT, one channel at a time, which bounds output rate.
// Synchronous active-low reset; buffer contents are never cleared, only head and fill.
// A full channel queue stalls the scanner; a stalled output holds the back end in B_OUT.
module crsf_frame_parser_channel_scaler_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    cfsc_in_if.sink                           i_rx,
    cfsc_out_if.source                        o_ch,
    input  logic                              i_cfg_we,
    input  logic [cfsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cfsc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    cfsc_pkg::t_front_cfg r_fcfg;
    cfsc_pkg::t_back_cfg  r_bcfg;

    logic                 push;
    logic                 full;
    logic                 pop;
    logic                 empty;
    cfsc_pkg::t_chan_item push_item;
    cfsc_pkg::t_chan_item head_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcfg.poly   <= cfsc_pkg::RST_CRC_POLY;
            r_fcfg.addr   <= cfsc_pkg::RST_ADDR;
            r_fcfg.ftype  <= cfsc_pkg::RST_TYPE;
            r_fcfg.max_pl <= cfsc_pkg::RST_MAXPL;
            r_bcfg.raw_at <= cfsc_pkg::RST_RAW_AT;
            r_bcfg.span   <= cfsc_pkg::RST_SPAN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cfsc_pkg::REG_CRC_POLY:    r_fcfg.poly   <= i_cfg_wdata[7:0];
                cfsc_pkg::REG_ACC_ADDR:    r_fcfg.addr   <= i_cfg_wdata[7:0];
                cfsc_pkg::REG_CH_TYPE:     r_fcfg.ftype  <= i_cfg_wdata[7:0];
                cfsc_pkg::REG_MAX_PL:      r_fcfg.max_pl <= i_cfg_wdata[cfsc_pkg::MAXPL_W-1:0];
                cfsc_pkg::REG_RAW_AT_1000: r_bcfg.raw_at <= i_cfg_wdata[cfsc_pkg::RAW_W-1:0];
                cfsc_pkg::REG_RAW_SPAN:    r_bcfg.span   <= i_cfg_wdata[cfsc_pkg::RAW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cfsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_fcfg),
        .i_rx    (i_rx),
        .o_push  (push),
        .o_item  (push_item),
        .i_full  (full)
    );

    cfsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_empty (empty)
    );

    cfsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_bcfg),
        .i_item  (head_item),
        .i_empty (empty),
        .o_pop   (pop),
        .o_ch    (o_ch)
    );
endmodule

@@ src/cfsc_checker.sv @@
`include "crsf_frame_parser_channel_scaler_top_assert.svh"

module cfsc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [cfsc_pkg::IDX_W-1:0] i_out_idx,
    input logic [cfsc_pkg::VAL_W-1:0] i_out_value,
    input logic                       i_out_last,
    input logic                       i_out_first
);
    `CFSC_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value) && $stable(i_out_idx), "output word changed while stalled")
    `CFSC_ASSERT(a_last_idx, i_clk, i_rst_n, i_out_valid && i_out_last |-> i_out_idx == cfsc_pkg::IDX_W'(cfsc_pkg::NUM_CHANNELS - 1), "last channel flag on wrong index")
    `CFSC_ASSERT(a_link_once, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_first |=> !(i_out_valid && i_out_first), "link-up mark after a later frame")
endmodule

bind crsf_frame_parser_channel_scaler_top cfsc_checker u_cfsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_ch.valid),
    .i_out_ready (o_ch.ready),
    .i_out_idx   (o_ch.channel_index),
    .i_out_value (o_ch.channel_value),
    .i_out_last  (o_ch.last_channel),
    .i_out_first (o_ch.link_came_up)
);

@@ test/tb_crsf_frame_parser_channel_scaler_top.sv @@
module tb_crsf_frame_parser_channel_scaler_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 6000;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int RANDOM_BYTES  = 6;

    typedef struct {
        logic [cfsc_pkg::IDX_W-1:0] idx;
        logic [cfsc_pkg::VAL_W-1:0] value;
        logic                       last;
        logic                       link_up;
    } t_chan_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [cfsc_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [cfsc_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    cfsc_in_if  rx_if ();
    cfsc_out_if ch_if ();

    crsf_frame_parser_channel_scaler_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_if),
        .o_ch        (ch_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // shadow copy of the block's registers and state
    logic [7:0]                   m_poly = cfsc_pkg::RST_CRC_POLY;
    logic [7:0]                   m_addr = cfsc_pkg::RST_ADDR;
    logic [7:0]                   m_ftype = cfsc_pkg::RST_TYPE;
    logic [cfsc_pkg::MAXPL_W-1:0] m_max_pl = cfsc_pkg::RST_MAXPL;
    logic [cfsc_pkg::RAW_W-1:0]   m_raw_at = cfsc_pkg::RST_RAW_AT;
    logic [cfsc_pkg::RAW_W-1:0]   m_span = cfsc_pkg::RST_SPAN;
    logic [7:0]                   rx_buf[$];
    bit                           link_up = 1'b0;

    t_chan_result expected_channels[$];
    int  fail_count = 0;
    int  cycle_count = 0;
    int  bytes_sent = 0;
    bit  quiet_mode = 1'b0;

    initial begin
        rx_if.valid = 1'b0;
        rx_if.rx_byte = '0;
        ch_if.ready = 1'b0;
    end

    function automatic logic [7:0] crc_next(logic [7:0] crc, logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ m_poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic void scale_channels();
        logic [cfsc_pkg::CH_PAYLOAD_BYTES*8-1:0] pl;
        t_chan_result r;
        int diff, span, v;
        for (int k = 0; k < cfsc_pkg::CH_PAYLOAD_BYTES; k++) begin
            pl[k*8 +: 8] = rx_buf[cfsc_pkg::PAYLOAD_OFS + k];
        end
        span = (m_span == 0) ? 1 : int'(m_span);
        for (int ch = 0; ch < cfsc_pkg::NUM_CHANNELS; ch++) begin
            diff = int'(pl[ch*cfsc_pkg::CHANNEL_BITS +: cfsc_pkg::CHANNEL_BITS]) - int'(m_raw_at);
            v = cfsc_pkg::SCALE_STEPS * diff / span + cfsc_pkg::SCALE_BASE;
            r.idx = ch[cfsc_pkg::IDX_W-1:0];
            r.value = v[cfsc_pkg::VAL_W-1:0];
            r.last = (ch == cfsc_pkg::NUM_CHANNELS - 1);
            r.link_up = 1'b0;
            expected_channels.push_back(r);
        end
    endfunction

    // parse state update for one accepted byte
    function automatic void parse_rx_byte(logic [7:0] b);
        int len, n, first_pos;
        logic [7:0] crc;
        bit first;
        n = 0;
        if (rx_buf.size() >= cfsc_pkg::BUFFER_DEPTH) void'(rx_buf.pop_front());
        rx_buf.push_back(b);
        while (rx_buf.size() > 1) begin
            len = rx_buf[1];
            if (len < cfsc_pkg::MIN_LEN || len > int'(m_max_pl) + cfsc_pkg::LEN_OVERHEAD) begin
                void'(rx_buf.pop_front());
            end else if (rx_buf.size() >= len + 2) begin
                crc = 8'h00;
                for (int i = cfsc_pkg::TYPE_OFS; i <= len; i++) crc = crc_next(crc, rx_buf[i]);
                if (rx_buf[len + 1] == crc) begin
                    if (rx_buf[0] == m_addr && rx_buf[cfsc_pkg::TYPE_OFS] == m_ftype
                            && len == cfsc_pkg::CH_FRAME_LEN) begin
                        first = !link_up;
                        link_up = 1'b1;
                        // frames past 32 results in one step are consumed silently
                        if (n + cfsc_pkg::NUM_CHANNELS <= 32) begin
                            first_pos = expected_channels.size();
                            scale_channels();
                            for (int i = first_pos; i < expected_channels.size(); i++)
                                expected_channels[i].link_up = first;
                            n += cfsc_pkg::NUM_CHANNELS;
                        end
                    end
                    repeat (len + 2) void'(rx_buf.pop_front());
                end else begin
                    void'(rx_buf.pop_front());
                end
            end else begin
                break;
            end
        end
    endfunction

    function automatic int draw_wait();
        if (quiet_mode) return 0;
        return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 13));
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        parse_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(logic [7:0] addr, logic [7:0] ftype, logic [7:0] pl[$],
                              bit bad_crc = 1'b0, int len_adj = 0);
        logic [7:0] crc;
        crc = crc_next(8'h00, ftype);
        foreach (pl[i]) crc = crc_next(crc, pl[i]);
        send_byte(addr);
        send_byte(8'(pl.size() + 2 + len_adj));
        send_byte(ftype);
        foreach (pl[i]) send_byte(pl[i]);
        send_byte(bad_crc ? crc ^ 8'(1 << $urandom_range(0, 7)) : crc);
    endtask

    function automatic void pack_channels(output logic [7:0] pl[$], input int mode);
        logic [cfsc_pkg::CH_PAYLOAD_BYTES*8-1:0] bits;
        logic [cfsc_pkg::CHANNEL_BITS-1:0] raw;
        for (int ch = 0; ch < cfsc_pkg::NUM_CHANNELS; ch++) begin
            case (mode)
                0: raw = '0;
                1: raw = '1;
                2: raw = m_raw_at;
                3: raw = m_raw_at + m_span;
                default: begin
                    case ($urandom_range(0, 5))
                        0: raw = '0;
                        1: raw = '1;
                        2: raw = cfsc_pkg::CHANNEL_BITS'(int'(m_raw_at)
                                 + int'($urandom_range(0, 3)) - 1);
                        default: raw = cfsc_pkg::CHANNEL_BITS'($urandom_range(0, 2047));
                    endcase
                end
            endcase
            bits[ch*cfsc_pkg::CHANNEL_BITS +: cfsc_pkg::CHANNEL_BITS] = raw;
        end
        pl = {};
        for (int k = 0; k < cfsc_pkg::CH_PAYLOAD_BYTES; k++) pl.push_back(bits[k*8 +: 8]);
    endfunction

    function automatic void random_payload(output logic [7:0] pl[$], input int n);
        pl = {};
        repeat (n) pl.push_back(8'($urandom_range(0, 255)));
    endfunction

    // receiver side: random stall before each word
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                ch_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            ch_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!ch_if.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_chan_result e;
        if (i_rst_n && ch_if.valid && ch_if.ready) begin
            if (expected_channels.size() == 0) begin
                $error("unexpected word: index %0d value %0d",
                       ch_if.channel_index, ch_if.channel_value);
                fail_count++;
            end else begin
                e = expected_channels.pop_front();
                if (ch_if.channel_index !== e.idx) begin
                    $error("channel_index exp %0d got %0d", e.idx, ch_if.channel_index);
                    fail_count++;
                end
                if (ch_if.channel_value !== e.value) begin
                    $error("channel_value exp %0d got %0d", e.value, ch_if.channel_value);
                    fail_count++;
                end
                if (ch_if.last_channel !== e.last) begin
                    $error("last_channel exp %0d got %0d", e.last, ch_if.last_channel);
                    fail_count++;
                end
                if (ch_if.link_came_up !== e.link_up) begin
                    $error("link_came_up exp %0d got %0d", e.link_up, ch_if.link_came_up);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[crsf_frame_parser_channel_scaler_top] ERROR");
            $finish;
        end
    end

    task automatic drain();
        rx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_channels.size() != 0) @(posedge i_clk);
        // scanner may still be rescanning bytes that make no word
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(cfsc_pkg::t_reg_idx idx, logic [cfsc_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        case (idx)
            cfsc_pkg::REG_CRC_POLY:    m_poly = data[7:0];
            cfsc_pkg::REG_ACC_ADDR:    m_addr = data[7:0];
            cfsc_pkg::REG_CH_TYPE:     m_ftype = data[7:0];
            cfsc_pkg::REG_MAX_PL:      m_max_pl = data[cfsc_pkg::MAXPL_W-1:0];
            cfsc_pkg::REG_RAW_AT_1000: m_raw_at = data[cfsc_pkg::RAW_W-1:0];
            cfsc_pkg::REG_RAW_SPAN:    m_span = data[cfsc_pkg::RAW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [7:0] poly, logic [7:0] addr, logic [7:0] ftype,
                             logic [cfsc_pkg::MAXPL_W-1:0] max_pl,
                             logic [cfsc_pkg::RAW_W-1:0] raw_at,
                             logic [cfsc_pkg::RAW_W-1:0] span);
        drain();
        write_reg(cfsc_pkg::REG_CRC_POLY, cfsc_pkg::CFG_DATA_W'(poly));
        write_reg(cfsc_pkg::REG_ACC_ADDR, cfsc_pkg::CFG_DATA_W'(addr));
        write_reg(cfsc_pkg::REG_CH_TYPE, cfsc_pkg::CFG_DATA_W'(ftype));
        write_reg(cfsc_pkg::REG_MAX_PL, cfsc_pkg::CFG_DATA_W'(max_pl));
        write_reg(cfsc_pkg::REG_RAW_AT_1000, cfsc_pkg::CFG_DATA_W'(raw_at));
        write_reg(cfsc_pkg::REG_RAW_SPAN, cfsc_pkg::CFG_DATA_W'(span));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_directed_frames();
        logic [7:0] pl[$];
        logic [7:0] bad_len[5];
        bad_len = '{8'd0, 8'd1, 8'd2, 8'd63, 8'd255};
        for (int m = 0; m < 4; m++) begin
            pack_channels(pl, m);
            send_frame(m_addr, m_ftype, pl);
        end
        pack_channels(pl, 4);
        send_frame(m_addr ^ 8'h01, m_ftype, pl);            // other address
        send_frame(m_addr, m_ftype, pl, 1'b1);              // bad crc
        void'(pl.pop_back());
        send_frame(m_addr, m_ftype, pl);                    // channel type, short length
        random_payload(pl, 0);
        send_frame(8'h00, 8'hFF, pl);                       // empty payload, length below MIN_LEN
        foreach (bad_len[i])
            send_byte(bad_len[i]);                          // bad length bytes
        random_payload(pl, int'(m_max_pl));
        send_frame(8'hFF, 8'h00, pl);                       // largest payload
    endtask

    task automatic test_buffer_overflow();
        logic [7:0] pl[$];
        // long run of junk forces byte drops and rescans
        send_byte(m_addr);
        send_byte(8'd60);
        repeat (66) send_byte(8'($urandom_range(0, 255)));
        pack_channels(pl, 4);
        send_frame(m_addr, m_ftype, pl);
    endtask

    task automatic test_random_traffic(int n_bytes);
        logic [7:0] pl[$];
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            quiet_mode = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    pack_channels(pl, 4);
                    send_frame(m_addr, m_ftype, pl);
                end
                6: begin
                    random_payload(pl, int'($urandom_range(0, 8)));
                    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pl);
                end
                7: begin
                    pack_channels(pl, 4);
                    send_frame(m_addr, m_ftype, pl, 1'b1);
                end
                8: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
                default: begin
                    pack_channels(pl, 4);
                    send_frame($urandom_range(0, 1) ? m_addr : 8'($urandom_range(0, 255)),
                               $urandom_range(0, 1) ? m_ftype : 8'($urandom_range(0, 255)),
                               pl, 1'b0, int'($urandom_range(0, 2)) - 1);
                end
            endcase
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_register_settings();
        configure(8'h07, 8'hEE, 8'h16, 6'd62, 11'd0, 11'd2047);
        test_random_traffic(RANDOM_BYTES);
        configure(8'hFF, 8'h00, 8'hFF, 6'd22, 11'd2047, 11'd1);
        test_random_traffic(RANDOM_BYTES);
        configure(8'h00, 8'hFF, 8'h00, 6'd62, 11'd1024, 11'd0);
        test_random_traffic(RANDOM_BYTES);
        configure(8'h31, 8'hC8, 8'h16, 6'd1, 11'd191, 11'd1639);
        test_random_traffic(RANDOM_BYTES);
        configure(8'h9B, 8'hC8, 8'h16, 6'd0, 11'd191, 11'd1639);
        test_random_traffic(RANDOM_BYTES);
        configure(cfsc_pkg::RST_CRC_POLY, cfsc_pkg::RST_ADDR, cfsc_pkg::RST_TYPE,
                  cfsc_pkg::RST_MAXPL, cfsc_pkg::RST_RAW_AT, cfsc_pkg::RST_SPAN);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_frames();
        test_buffer_overflow();
        test_register_settings();
        drain();
        if (fail_count == 0 && expected_channels.size() == 0) begin
            $display("[crsf_frame_parser_channel_scaler_top] OK");
        end else begin
            $display("[crsf_frame_parser_channel_scaler_top] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/cfsc_pkg.sv
src/cfsc_in_if.sv
src/cfsc_out_if.sv
src/cfsc_ram.sv
src/cfsc_queue.sv
src/cfsc_front.sv
src/cfsc_back.sv
src/crsf_frame_parser_channel_scaler_top.sv
src/cfsc_checker.sv
test/tb_crsf_frame_parser_channel_scaler_top.sv
